// ===== design/nps_pkg.sv =====
// Shared types, constants and codes for the nearest polyline segment finder.
package nps_pkg;

    // Default table depth.
    localparam int MAX_WAYPOINTS_DEF = 64;

    // Field widths fixed by the interface.
    localparam int COORD_W     = 32;
    localparam int ENTRY_W     = 6;
    localparam int OUT_IDX_W   = 6;
    localparam int FRAC_W      = 17;
    localparam int COUNT_W     = 7;
    localparam int CFG_DATA_W  = 7;
    localparam int CFG_INDEX_W = 1;

    // Datapath widths.
    localparam int DIFF_W = 33;   // coordinate difference
    localparam int MUL_W  = 34;   // shared signed multiplier operand
    localparam int ACC_W  = 68;   // product, squared length and dot product
    localparam int DK_W   = 51;   // scaled offset from the projected point
    localparam int MAG_W  = 50;   // magnitude of that offset
    localparam int HALF_W = 25;   // half of the magnitude for partial products
    localparam int DIST_W = 104;  // squared distance
    localparam int DIV_STEPS = 16;

    localparam logic [FRAC_W-1:0] FRAC_ONE  = 17'd65536;
    localparam logic [FRAC_W-1:0] FRAC_HALF = 17'd32768;

    // Request function codes.
    localparam logic FUNC_STORE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_WAYPOINT_COUNT = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATH_LOOPS     = 1'd1;

    typedef struct packed {
        logic                      func;
        logic [ENTRY_W-1:0]        entry_index;
        logic signed [COORD_W-1:0] coord_east;
        logic signed [COORD_W-1:0] coord_north;
        logic signed [COORD_W-1:0] coord_up;
    } nps_in_t;

    typedef struct packed {
        logic [OUT_IDX_W-1:0] nearest_waypoint;
        logic [OUT_IDX_W-1:0] segment_end;
        logic [FRAC_W-1:0]    along_fraction;
        logic                 too_short;
    } nps_out_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_READ, ST_LATCH, ST_DIFF, ST_SS_MUL, ST_SS_ACC,
        ST_DOT_MUL, ST_DOT_ACC, ST_FRAC, ST_DIV, ST_TS_MUL, ST_MAG,
        ST_SQ_MUL, ST_SQ_ACC, ST_CMP, ST_NEXT, ST_DONE
    } nps_state_t;

    typedef enum logic [4:0] {
        OP_NOP, OP_LOAD_POS, OP_LATCH_FIRST, OP_LATCH_NEXT, OP_LATCH_CLOSE,
        OP_DIFF, OP_MUL_SS, OP_ACC_SS, OP_MUL_DOT, OP_ACC_DOT, OP_FRAC_INIT,
        OP_DIV_STEP, OP_MUL_TS, OP_MAG, OP_MUL_SQ, OP_ACC_SQ, OP_COMPARE,
        OP_FINISH
    } nps_op_t;

    typedef struct packed {
        nps_op_t    op;
        logic [1:0] comp;
        logic [1:0] part;
        logic       too_short;
    } nps_cmd_t;

    typedef struct packed {
        logic zero_len;
        logic frac_direct;
        logic out_free;
    } nps_status_t;

endpackage

// ===== design/nps_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module nps_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== design/nps_datapath.sv =====
// Datapath: segment projection, fraction divider, squared distance and best tracking.
module nps_datapath
    import nps_pkg::*;
#(
    parameter int MAX_WAYPOINTS = MAX_WAYPOINTS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  nps_cmd_t                         cmd,
    input  logic [$clog2(MAX_WAYPOINTS)-1:0] seg_start,
    input  logic [$clog2(MAX_WAYPOINTS)-1:0] seg_end,
    input  nps_in_t                          s_data,
    input  logic [3*COORD_W-1:0]             rd_data,
    output nps_status_t                      status,
    output logic                             m_valid,
    input  logic                             m_ready,
    output nps_out_t                         m_data
);

    localparam int IW = $clog2(MAX_WAYPOINTS);

    logic signed [COORD_W-1:0] pos_reg   [3];
    logic signed [COORD_W-1:0] prev_reg  [3];
    logic signed [COORD_W-1:0] cur_reg   [3];
    logic signed [COORD_W-1:0] first_reg [3];
    logic signed [COORD_W-1:0] wp        [3];
    logic signed [DIFF_W-1:0]  s_reg     [3];
    logic signed [DIFF_W-1:0]  ap_reg    [3];
    logic signed [ACC_W-1:0]   ss_reg, dot_reg, prod_reg;
    logic [ACC_W-1:0]          rem_reg;
    logic [FRAC_W-1:0]         t_reg, best_t_reg;
    logic [HALF_W-1:0]         mh_reg, ml_reg;
    logic [DIST_W-1:0]         d2_reg, best_d2_reg;
    logic [IW-1:0]             best_end_reg, best_start_reg;
    logic                      have_reg;
    logic                      m_valid_reg;
    nps_out_t                  m_data_reg;

    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [ACC_W-1:0]   prod_full;
    logic [ACC_W-1:0]          rem_shift;
    logic signed [DK_W-1:0]    ap_shift, dk, dk_abs;
    logic [DIST_W-1:0]         sq_term;
    logic [1:0]                c;

    assign c = cmd.comp;

    // Split the read word into east, north and up.
    assign wp[0] = rd_data[3*COORD_W-1:2*COORD_W];
    assign wp[1] = rd_data[2*COORD_W-1:COORD_W];
    assign wp[2] = rd_data[COORD_W-1:0];

    // Shared multiplier operand selection.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            OP_MUL_SS: begin
                mul_a = MUL_W'(s_reg[c]);
                mul_b = MUL_W'(s_reg[c]);
            end
            OP_MUL_DOT: begin
                mul_a = MUL_W'(ap_reg[c]);
                mul_b = MUL_W'(s_reg[c]);
            end
            OP_MUL_TS: begin
                mul_a = {{(MUL_W-FRAC_W){1'b0}}, t_reg};
                mul_b = MUL_W'(s_reg[c]);
            end
            OP_MUL_SQ: begin
                case (cmd.part)
                    2'd0: begin
                        mul_a = {{(MUL_W-HALF_W){1'b0}}, mh_reg};
                        mul_b = {{(MUL_W-HALF_W){1'b0}}, mh_reg};
                    end
                    2'd1: begin
                        mul_a = {{(MUL_W-HALF_W){1'b0}}, mh_reg};
                        mul_b = {{(MUL_W-HALF_W){1'b0}}, ml_reg};
                    end
                    default: begin
                        mul_a = {{(MUL_W-HALF_W){1'b0}}, ml_reg};
                        mul_b = {{(MUL_W-HALF_W){1'b0}}, ml_reg};
                    end
                endcase
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_full = mul_a * mul_b;

    // Helpers for the divider step, the offset magnitude and the square terms.
    assign rem_shift = {rem_reg[ACC_W-2:0], 1'b0};
    assign ap_shift  = {{(DK_W-DIFF_W-16){ap_reg[c][DIFF_W-1]}}, ap_reg[c], 16'b0};
    assign dk        = ap_shift - DK_W'(prod_reg);
    assign dk_abs    = dk[DK_W-1] ? -dk : dk;

    always_comb begin
        case (cmd.part)
            2'd0:    sq_term = DIST_W'(prod_reg[MAG_W-1:0]) << (2 * HALF_W);
            2'd1:    sq_term = DIST_W'(prod_reg[MAG_W-1:0]) << (HALF_W + 1);
            default: sq_term = DIST_W'(prod_reg[MAG_W-1:0]);
        endcase
    end

    // Status back to the controller.
    assign status.zero_len    = (s_reg[0] == '0) && (s_reg[1] == '0) && (s_reg[2] == '0);
    assign status.frac_direct = (dot_reg <= 0) || (dot_reg >= ss_reg);
    assign status.out_free    = !m_valid_reg || m_ready;

    // Working registers.
    always_ff @(posedge aclk) begin
        unique case (cmd.op) inside
            OP_LOAD_POS: begin
                pos_reg[0]     <= s_data.coord_east;
                pos_reg[1]     <= s_data.coord_north;
                pos_reg[2]     <= s_data.coord_up;
                best_t_reg     <= '0;
                best_end_reg   <= IW'(1);
                best_start_reg <= '0;
            end
            OP_LATCH_FIRST: begin
                first_reg <= wp;
                cur_reg   <= wp;
            end
            OP_LATCH_NEXT: begin
                prev_reg <= cur_reg;
                cur_reg  <= wp;
            end
            OP_LATCH_CLOSE: begin
                prev_reg <= cur_reg;
                cur_reg  <= first_reg;
            end
            OP_DIFF: begin
                for (int k = 0; k < 3; k++) begin
                    s_reg[k]  <= {cur_reg[k][COORD_W-1], cur_reg[k]}
                               - {prev_reg[k][COORD_W-1], prev_reg[k]};
                    ap_reg[k] <= {pos_reg[k][COORD_W-1], pos_reg[k]}
                               - {prev_reg[k][COORD_W-1], prev_reg[k]};
                end
                ss_reg  <= '0;
                dot_reg <= '0;
                d2_reg  <= '0;
            end
            OP_MUL_SS, OP_MUL_DOT, OP_MUL_TS, OP_MUL_SQ: begin
                prod_reg <= prod_full;
            end
            OP_ACC_SS: begin
                ss_reg <= ss_reg + prod_reg;
            end
            OP_ACC_DOT: begin
                dot_reg <= dot_reg + prod_reg;
            end
            OP_FRAC_INIT: begin
                rem_reg <= $unsigned(dot_reg);
                if (dot_reg <= 0) begin
                    t_reg <= '0;
                end else if (dot_reg >= ss_reg) begin
                    t_reg <= FRAC_ONE;
                end else begin
                    t_reg <= '0;
                end
            end
            OP_DIV_STEP: begin
                if (rem_shift >= $unsigned(ss_reg)) begin
                    rem_reg <= rem_shift - $unsigned(ss_reg);
                    t_reg   <= {t_reg[FRAC_W-2:0], 1'b1};
                end else begin
                    rem_reg <= rem_shift;
                    t_reg   <= {t_reg[FRAC_W-2:0], 1'b0};
                end
            end
            OP_MAG: begin
                mh_reg <= dk_abs[MAG_W-1:HALF_W];
                ml_reg <= dk_abs[HALF_W-1:0];
            end
            OP_ACC_SQ: begin
                d2_reg <= d2_reg + sq_term;
            end
            OP_COMPARE: begin
                if (!have_reg || (d2_reg < best_d2_reg)) begin
                    best_d2_reg    <= d2_reg;
                    best_t_reg     <= t_reg;
                    best_end_reg   <= seg_end;
                    best_start_reg <= seg_start;
                end
            end
            default: begin
            end
        endcase
    end

    // Best-found flag and result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.op == OP_LOAD_POS) begin
                have_reg <= 1'b0;
            end else if (cmd.op == OP_COMPARE) begin
                have_reg <= 1'b1;
            end
            if (cmd.op == OP_FINISH) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (cmd.op == OP_FINISH) begin
            if (cmd.too_short) begin
                m_data_reg <= '{nearest_waypoint: '0, segment_end: '0,
                                along_fraction: '0, too_short: 1'b1};
            end else begin
                m_data_reg.nearest_waypoint <= (best_t_reg >= FRAC_HALF)
                    ? OUT_IDX_W'(best_end_reg) : OUT_IDX_W'(best_start_reg);
                m_data_reg.segment_end      <= OUT_IDX_W'(best_end_reg);
                m_data_reg.along_fraction   <= best_t_reg;
                m_data_reg.too_short        <= 1'b0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // The fraction never exceeds one, and a short path gives zero fields.
    a_frac_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_data_reg.along_fraction <= FRAC_ONE))
        else $error("along_fraction above one");
    a_short_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.too_short) |->
        (m_data_reg.segment_end == '0 && m_data_reg.nearest_waypoint == '0
         && m_data_reg.along_fraction == '0))
        else $error("short path result not zero");

endmodule

// ===== design/nps_controller.sv =====
// Controller: configuration registers and the segment walk state machine.
module nps_controller
    import nps_pkg::*;
#(
    parameter int MAX_WAYPOINTS = MAX_WAYPOINTS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [CFG_INDEX_W-1:0]           cfg_index,
    input  logic [CFG_DATA_W-1:0]            cfg_wdata,
    input  logic                             s_valid,
    input  logic                             s_func,
    output logic                             s_ready,
    input  nps_status_t                      status,
    output nps_cmd_t                         cmd,
    output logic [$clog2(MAX_WAYPOINTS)-1:0] rd_addr,
    output logic [$clog2(MAX_WAYPOINTS)-1:0] seg_start,
    output logic [$clog2(MAX_WAYPOINTS)-1:0] seg_end
);

    localparam int IW = $clog2(MAX_WAYPOINTS);
    localparam int CW = $clog2(MAX_WAYPOINTS + 1);

    nps_state_t           state_reg, state_next;
    logic [COUNT_W-1:0]   count_reg;
    logic                 loops_reg;
    logic [IW-1:0]        idx_reg, idx_next;
    logic [1:0]           comp_reg, comp_next;
    logic [1:0]           part_reg, part_next;
    logic [3:0]           div_cnt_reg, div_cnt_next;
    logic                 closing_reg, closing_next;
    logic                 short_reg, short_next;
    logic [CW-1:0]        n_cl;
    logic                 more_segs;
    logic                 query_acc;

    // Waypoint count clamped to the table depth.
    assign n_cl = (32'(count_reg) > 32'(MAX_WAYPOINTS)) ? CW'(MAX_WAYPOINTS)
                                                         : CW'(count_reg);
    assign more_segs = (CW'(idx_reg) + CW'(1)) < n_cl;
    assign query_acc = s_valid && s_ready && (s_func == FUNC_QUERY);

    assign s_ready   = (state_reg == ST_IDLE);
    assign rd_addr   = idx_reg;
    assign seg_start = closing_reg ? idx_reg : idx_reg - IW'(1);
    assign seg_end   = closing_reg ? '0 : idx_reg;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            loops_reg <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_WAYPOINT_COUNT: count_reg <= cfg_wdata[COUNT_W-1:0];
                CFG_PATH_LOOPS:     loops_reg <= cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:    if (query_acc) begin
                            state_next = (n_cl < CW'(2)) ? ST_DONE : ST_READ;
                        end
            ST_READ:    state_next = ST_LATCH;
            ST_LATCH:   state_next = (idx_reg == '0) ? ST_READ : ST_DIFF;
            ST_DIFF:    state_next = ST_SS_MUL;
            ST_SS_MUL:  state_next = status.zero_len ? ST_NEXT : ST_SS_ACC;
            ST_SS_ACC:  state_next = (comp_reg == 2'd2) ? ST_DOT_MUL : ST_SS_MUL;
            ST_DOT_MUL: state_next = ST_DOT_ACC;
            ST_DOT_ACC: state_next = (comp_reg == 2'd2) ? ST_FRAC : ST_DOT_MUL;
            ST_FRAC:    state_next = status.frac_direct ? ST_TS_MUL : ST_DIV;
            ST_DIV:     state_next = (div_cnt_reg == 4'(DIV_STEPS - 1)) ? ST_TS_MUL
                                                                        : ST_DIV;
            ST_TS_MUL:  state_next = ST_MAG;
            ST_MAG:     state_next = ST_SQ_MUL;
            ST_SQ_MUL:  state_next = ST_SQ_ACC;
            ST_SQ_ACC:  begin
                            if (part_reg != 2'd2) begin
                                state_next = ST_SQ_MUL;
                            end else if (comp_reg == 2'd2) begin
                                state_next = ST_CMP;
                            end else begin
                                state_next = ST_TS_MUL;
                            end
                        end
            ST_CMP:     state_next = ST_NEXT;
            ST_NEXT:    begin
                            if (closing_reg) begin
                                state_next = ST_DONE;
                            end else if (more_segs) begin
                                state_next = ST_READ;
                            end else if (loops_reg) begin
                                state_next = ST_DIFF;
                            end else begin
                                state_next = ST_DONE;
                            end
                        end
            ST_DONE:    if (status.out_free) begin
                            state_next = ST_IDLE;
                        end
            default:    state_next = ST_IDLE;
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        cmd.op        = OP_NOP;
        cmd.comp      = comp_reg;
        cmd.part      = part_reg;
        cmd.too_short = short_reg;
        unique case (state_reg)
            ST_IDLE:    if (query_acc) cmd.op = OP_LOAD_POS;
            ST_LATCH:   cmd.op = (idx_reg == '0) ? OP_LATCH_FIRST : OP_LATCH_NEXT;
            ST_DIFF:    cmd.op = OP_DIFF;
            ST_SS_MUL:  cmd.op = OP_MUL_SS;
            ST_SS_ACC:  cmd.op = OP_ACC_SS;
            ST_DOT_MUL: cmd.op = OP_MUL_DOT;
            ST_DOT_ACC: cmd.op = OP_ACC_DOT;
            ST_FRAC:    cmd.op = OP_FRAC_INIT;
            ST_DIV:     cmd.op = OP_DIV_STEP;
            ST_TS_MUL:  cmd.op = OP_MUL_TS;
            ST_MAG:     cmd.op = OP_MAG;
            ST_SQ_MUL:  cmd.op = OP_MUL_SQ;
            ST_SQ_ACC:  cmd.op = OP_ACC_SQ;
            ST_CMP:     cmd.op = OP_COMPARE;
            ST_NEXT:    if (!closing_reg && !more_segs && loops_reg) begin
                            cmd.op = OP_LATCH_CLOSE;
                        end
            ST_DONE:    if (status.out_free) cmd.op = OP_FINISH;
            default:    cmd.op = OP_NOP;
        endcase
    end

    // Counters for waypoint, component, partial product and divider step, and the closing and short flags.
    always_comb begin
        idx_next     = idx_reg;
        comp_next    = comp_reg;
        part_next    = part_reg;
        div_cnt_next = div_cnt_reg;
        closing_next = closing_reg;
        short_next   = short_reg;
        case (state_reg) inside
            ST_IDLE: begin
                if (query_acc) begin
                    idx_next     = '0;
                    closing_next = 1'b0;
                    short_next   = n_cl < CW'(2);
                end
            end
            ST_LATCH: begin
                if (idx_reg == '0) idx_next = IW'(1);
            end
            ST_DIFF: begin
                comp_next = '0;
                part_next = '0;
            end
            ST_SS_ACC, ST_DOT_ACC: begin
                comp_next = (comp_reg == 2'd2) ? 2'd0 : comp_reg + 2'd1;
            end
            ST_FRAC: begin
                div_cnt_next = '0;
            end
            ST_DIV: begin
                div_cnt_next = div_cnt_reg + 4'd1;
            end
            ST_SQ_ACC: begin
                if (part_reg == 2'd2) begin
                    part_next = '0;
                    comp_next = comp_reg + 2'd1;
                end else begin
                    part_next = part_reg + 2'd1;
                end
            end
            ST_NEXT: begin
                if (!closing_reg && more_segs) begin
                    idx_next = idx_reg + IW'(1);
                end else if (!closing_reg && loops_reg) begin
                    closing_next = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // State and counter registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            comp_reg    <= '0;
            part_reg    <= '0;
            div_cnt_reg <= '0;
            closing_reg <= 1'b0;
            short_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            comp_reg    <= comp_next;
            part_reg    <= part_next;
            div_cnt_reg <= div_cnt_next;
            closing_reg <= closing_next;
            short_reg   <= short_next;
        end
    end

    // A query request always starts a walk; a finished result returns to idle.
    a_query_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        query_acc |=> (state_reg != ST_IDLE))
        else $error("query request did not start a walk");
    a_done_leaves: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && status.out_free) |=> (state_reg == ST_IDLE))
        else $error("finished query did not return to idle");

endmodule

// ===== design/nearest_polyline_segment_finder_top.sv =====
// Top level of the nearest polyline segment finder.
//
//  Channel | Direction | Handshake           | Payload
//  s_      | in        | s_valid / s_ready   | nps_in_t  (store or query request)
//  m_      | out       | m_valid / m_ready   | nps_out_t (one result per query)
//  cfg_    | in        | cfg_we              | cfg_index, cfg_wdata
//
// A store request writes one waypoint slot.
// A query's duration grows with each waypoint read and with each segment, most for a
// divided fraction, less when the fraction clamps and least for a zero-length segment;
// it is set by the one shared multiplier and the 16-step divider. A path of fewer than
// two waypoints skips the walk and goes straight to the result.
// Reset is synchronous and active low; the waypoint tables are not cleared.
// Requests are taken only in idle; a finished result waits in the output register,
// and a second query holds at its end until that register frees.
module nearest_polyline_segment_finder_top
    import nps_pkg::*;
#(
    parameter int MAX_WAYPOINTS = MAX_WAYPOINTS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  nps_in_t                s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output nps_out_t               m_data
);

    localparam int IW = $clog2(MAX_WAYPOINTS);

    nps_cmd_t              cmd;
    nps_status_t           status;
    logic [IW-1:0]         rd_addr, seg_start, seg_end;
    logic [3*COORD_W-1:0]  rd_data;
    logic                  wr_en;

    // Store requests write the waypoint tables directly.
    assign wr_en = s_valid && s_ready && (s_data.func == FUNC_STORE)
                && (32'(s_data.entry_index) < 32'(MAX_WAYPOINTS));

    nps_ram #(
        .WIDTH (3 * COORD_W),
        .DEPTH (MAX_WAYPOINTS)
    ) u_path_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (IW'(s_data.entry_index)),
        .wr_data ({s_data.coord_east, s_data.coord_north, s_data.coord_up}),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    nps_controller #(
        .MAX_WAYPOINTS (MAX_WAYPOINTS)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_func    (s_data.func),
        .s_ready   (s_ready),
        .status    (status),
        .cmd       (cmd),
        .rd_addr   (rd_addr),
        .seg_start (seg_start),
        .seg_end   (seg_end)
    );

    nps_datapath #(
        .MAX_WAYPOINTS (MAX_WAYPOINTS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .seg_start (seg_start),
        .seg_end   (seg_end),
        .s_data    (s_data),
        .rd_data   (rd_data),
        .status    (status),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

// ===== verif/nps_result_checker.sv =====
// Watches the channels, predicts every query result and compares it.
`timescale 1ns / 1ps

module nps_result_checker
    import nps_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   s_valid,
    input  logic                   s_ready,
    input  nps_in_t                s_data,
    input  logic                   m_valid,
    input  logic                   m_ready,
    input  nps_out_t               m_data,
    output int                     fail_count,
    output int                     pending
);

    typedef logic signed [127:0] wide_t;

    // Shadow copy of the path tables and the registers.
    logic signed [COORD_W-1:0] east_tab [64];
    logic signed [COORD_W-1:0] north_tab [64];
    logic signed [COORD_W-1:0] up_tab [64];
    logic [COUNT_W-1:0] path_count;
    logic               loop_on;
    nps_out_t           result_queue [$];

    // Projects a position onto segment ia -> ib; returns 0 for a zero-length segment.
    function automatic logic project_segment(int ia, int ib, wide_t pe, wide_t pn, wide_t pu,
                                             output logic [FRAC_W-1:0] frac,
                                             output wide_t seg_d2);
        wide_t sx, sy, sz, ax, ay, az, ss, dot, t, dx, dy, dz;
        sx = wide_t'(east_tab[ib]) - wide_t'(east_tab[ia]);
        sy = wide_t'(north_tab[ib]) - wide_t'(north_tab[ia]);
        sz = wide_t'(up_tab[ib]) - wide_t'(up_tab[ia]);
        ax = pe - wide_t'(east_tab[ia]);
        ay = pn - wide_t'(north_tab[ia]);
        az = pu - wide_t'(up_tab[ia]);
        frac = '0;
        seg_d2 = '0;
        if (sx == 0 && sy == 0 && sz == 0) begin
            return 1'b0;
        end
        ss  = sx * sx + sy * sy + sz * sz;
        dot = ax * sx + ay * sy + az * sz;
        if (dot <= 0) begin
            t = 0;
        end else if (dot >= ss) begin
            t = 65536;
        end else begin
            t = (dot * 65536) / ss;
        end
        dx = ax * 65536 - t * sx;
        dy = ay * 65536 - t * sy;
        dz = az * 65536 - t * sz;
        seg_d2 = dx * dx + dy * dy + dz * dz;
        frac = t[FRAC_W-1:0];
        return 1'b1;
    endfunction

    // Expected result of one query against the current path.
    function automatic nps_out_t nearest_on_path(nps_in_t q);
        nps_out_t r;
        int n;
        logic [FRAC_W-1:0] frac, best_frac;
        wide_t seg_d2, top_d2, pe, pn, pu;
        logic found, closing;
        int best_end;
        r = '0;
        n = (path_count > 64) ? 64 : int'(path_count);
        if (n < 2) begin
            r.too_short = 1'b1;
            return r;
        end
        pe = wide_t'(q.coord_east);
        pn = wide_t'(q.coord_north);
        pu = wide_t'(q.coord_up);
        found = 1'b0;
        closing = 1'b0;
        best_end = 1;
        best_frac = '0;
        top_d2 = '0;
        for (int i = 1; i < n; i++) begin
            if (project_segment(i - 1, i, pe, pn, pu, frac, seg_d2) &&
                    (!found || seg_d2 < top_d2)) begin
                found = 1'b1;
                top_d2 = seg_d2;
                best_end = i;
                best_frac = frac;
            end
        end
        // The closing segment is tried last, so ties keep the earlier one.
        if (loop_on && project_segment(n - 1, 0, pe, pn, pu, frac, seg_d2) &&
                (!found || seg_d2 < top_d2)) begin
            closing = 1'b1;
            best_end = 0;
            best_frac = frac;
        end
        if (closing) begin
            r.nearest_waypoint = (best_frac >= FRAC_HALF) ? 6'd0 : OUT_IDX_W'(n - 1);
        end else begin
            r.nearest_waypoint = (best_frac >= FRAC_HALF) ? OUT_IDX_W'(best_end)
                                                           : OUT_IDX_W'(best_end - 1);
        end
        r.segment_end = OUT_IDX_W'(best_end);
        r.along_fraction = best_frac;
        return r;
    endfunction

    // Track registers and requests, and check every result as it leaves.
    always @(posedge aclk) begin
        nps_out_t exp_r;
        if (!aresetn) begin
            path_count <= '0;
            loop_on <= 1'b0;
            fail_count = 0;
            result_queue.delete();
        end else begin
            if (cfg_we) begin
                if (cfg_index == CFG_WAYPOINT_COUNT) begin
                    path_count <= cfg_wdata[COUNT_W-1:0];
                end else if (cfg_index == CFG_PATH_LOOPS) begin
                    loop_on <= cfg_wdata[0];
                end
            end
            if (s_valid && s_ready) begin
                if (s_data.func == FUNC_STORE) begin
                    east_tab[s_data.entry_index] = s_data.coord_east;
                    north_tab[s_data.entry_index] = s_data.coord_north;
                    up_tab[s_data.entry_index] = s_data.coord_up;
                end else begin
                    result_queue.push_back(nearest_on_path(s_data));
                end
            end
            if (m_valid && m_ready) begin
                if (result_queue.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("unexpected result %h", m_data);
                    end
                end else begin
                    exp_r = result_queue.pop_front();
                    if (m_data !== exp_r) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("mismatch: expected near=%0d end=%0d frac=%0d short=%0b",
                                     exp_r.nearest_waypoint, exp_r.segment_end,
                                     exp_r.along_fraction, exp_r.too_short);
                            $display("          actual   near=%0d end=%0d frac=%0d short=%0b",
                                     m_data.nearest_waypoint, m_data.segment_end,
                                     m_data.along_fraction, m_data.too_short);
                        end
                    end
                end
            end
        end
        pending = result_queue.size();
    end

endmodule

// ===== verif/tb_nearest_polyline_segment_finder_top.sv =====
// Stimulus and verdict for the nearest polyline segment finder.
`timescale 1ns / 1ps

module tb_nearest_polyline_segment_finder_top;
    import nps_pkg::*;

    localparam logic signed [31:0] C_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] C_MAX = 32'sh7FFF_FFFF;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_WAYPOINT_COUNT;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    nps_in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    nps_out_t m_data;
    int fail_count, pending;
    logic quiet = 1'b0;
    logic [63:0] filled = '0;
    int stall_left = 0;

    always #2 aclk = ~aclk;

    nearest_polyline_segment_finder_top uut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata), .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    nps_result_checker checker_i (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata), .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .fail_count(fail_count), .pending(pending)
    );

    // Result side stalls in bursts, except in the quiet tail of the run.
    always @(negedge aclk) begin
        if (quiet) begin
            m_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 18);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Last stored waypoint, reused to make zero-length segments.
    logic signed [31:0] last_e = 0, last_n = 0, last_u = 0;
    always @(posedge aclk) begin
        if (s_valid && s_ready && s_data.func == FUNC_STORE) begin
            last_e <= s_data.coord_east;
            last_n <= s_data.coord_north;
            last_u <= s_data.coord_up;
        end
    end
    function automatic logic signed [31:0] checker_copy_e(); return last_e; endfunction
    function automatic logic signed [31:0] checker_copy_n(); return last_n; endfunction
    function automatic logic signed [31:0] checker_copy_u(); return last_u; endfunction

    // Hands one request over; called and returns at a falling edge.
    task automatic send(nps_in_t req);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        if (req.func == FUNC_STORE) begin
            filled[req.entry_index] = 1'b1;
        end
    endtask

    task automatic store(int slot, logic signed [31:0] e, logic signed [31:0] n,
                         logic signed [31:0] u);
        nps_in_t req;
        req = '{func: FUNC_STORE, entry_index: ENTRY_W'(slot),
                coord_east: e, coord_north: n, coord_up: u};
        send(req);
    endtask

    task automatic query(logic signed [31:0] e, logic signed [31:0] n, logic signed [31:0] u);
        nps_in_t req;
        req = '{func: FUNC_QUERY, entry_index: ENTRY_W'($urandom_range(0, 63)),
                coord_east: e, coord_north: n, coord_up: u};
        send(req);
    endtask

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return ($urandom_range(0, 1) != 0) ? C_MIN : C_MAX;
            default: return $signed($urandom_range(0, 2000000)) - 1000000;
        endcase
    endfunction

    // Reconfigures the path once the block is idle, then fills any slot it uses.
    task automatic set_path(int count, logic loops);
        int used;
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_WAYPOINT_COUNT;
        cfg_wdata <= CFG_DATA_W'(count);
        @(negedge aclk);
        cfg_index <= CFG_PATH_LOOPS;
        cfg_wdata <= CFG_DATA_W'(loops);
        @(negedge aclk);
        cfg_we <= 1'b0;
        used = (count > 64) ? 64 : count;
        for (int i = 0; i < used; i++) begin
            if (!filled[i]) store(i, rand_coord(), rand_coord(), rand_coord());
        end
    endtask

    int counts [8] = '{5, 2, 64, 127, 3, 0, 1, 10};

    initial begin
        int slot;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Too few waypoints.
        set_path(0, 1'b0);
        query(C_MAX, C_MIN, 0);
        set_path(1, 1'b1);
        query(C_MIN, C_MAX, -1);

        // Extreme waypoints, a zero-length segment and the closing segment.
        store(0, C_MIN, C_MIN, C_MIN);
        store(1, C_MAX, C_MAX, C_MAX);
        store(2, C_MAX, C_MAX, C_MAX);
        store(3, 0, 0, 0);
        set_path(4, 1'b1);
        query(C_MAX, C_MAX, C_MAX);
        query(C_MIN, 0, C_MAX);
        query(0, 0, 0);
        query(-32'sh4000_0000, -32'sh4000_0000, -32'sh4000_0000);
        query(C_MIN, C_MIN, C_MIN);

        // Equal distances to two segments at their shared corner.
        store(0, 0, 0, 0);
        store(1, 32'sh1_0000, 0, 0);
        store(2, 32'sh1_0000, 32'sh1_0000, 0);
        set_path(3, 1'b0);
        query(32'sh2_0000, -32'sh1_0000, 0);
        query(32'sh8000, 0, 0);

        // Every segment of zero length.
        store(0, 5, 5, 5);
        store(1, 5, 5, 5);
        set_path(2, 1'b1);
        query(100, -100, 7);

        // Random phases; the last one runs without idling.
        foreach (counts[k]) begin
            set_path(counts[k], k % 2 == 0);
            if (k == 7) quiet = 1'b1;
            repeat (8) begin
                if ($urandom_range(0, 3) == 0) begin
                    slot = $urandom_range(0, 63);
                    if ($urandom_range(0, 2) == 0 && filled[0]) begin
                        store(slot, checker_copy_e(), checker_copy_n(), checker_copy_u());
                    end else begin
                        store(slot, rand_coord(), rand_coord(), rand_coord());
                    end
                end else begin
                    query(rand_coord(), rand_coord(), rand_coord());
                end
            end
        end
        s_valid <= 1'b0;
        quiet = 1'b1;
        while (pending != 0) @(negedge aclk);
        repeat (100) @(negedge aclk);
        if (fail_count == 0) begin
            $display("nearest_polyline_segment_finder_top regression: pass");
        end else begin
            $display("nearest_polyline_segment_finder_top regression: fail");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("nearest_polyline_segment_finder_top regression: fail");
        $finish;
    end

endmodule
